### hdl/dcp_pkg.sv
// ----------------------------------------------------------------------------
// Dichromat color projection package
// Shared fixed-point types, constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package dcp_pkg;

    localparam int DCP_FRACTION_BITS = 15;
    localparam int DCP_IFRAC = 24;
    localparam int DCP_W = 32;
    localparam int DCP_DIV_STEPS = DCP_W - 1;
    localparam int DCP_DIV_LEAD = DCP_DIV_STEPS - DCP_IFRAC;
    localparam int DCP_CFG_W = 20;
    localparam int DCP_CFG_SHIFT = 8;
    localparam int DCP_ADDR_W = 4;
    localparam int DCP_CH_W = 16;
    localparam int DCP_OUT_W = 17;

    localparam logic [1:0] DCP_REG_CU = 2'd0;
    localparam logic [1:0] DCP_REG_CV = 2'd1;
    localparam logic [1:0] DCP_REG_SLOPE = 2'd2;
    localparam logic [1:0] DCP_REG_ICPT = 2'd3;

    localparam logic signed [DCP_CFG_W-1:0] DCP_CU_RESET = 20'sd48169;
    localparam logic signed [DCP_CFG_W-1:0] DCP_CV_RESET = 20'sd17367;
    localparam logic signed [DCP_CFG_W-1:0] DCP_SLOPE_RESET = 20'sd83458;
    localparam logic signed [DCP_CFG_W-1:0] DCP_ICPT_RESET = -20'sd4843;

    typedef logic signed [DCP_W-1:0] fx_t;

    localparam fx_t DCP_ONE = fx_t'(longint'(1) <<< DCP_IFRAC);
    localparam fx_t DCP_SAT_HI = 32'sh7FFF_FFFF;
    localparam fx_t DCP_SAT_LO = 32'sh8000_0000;

    function automatic longint cfx(input longint n);
        return (n * (longint'(1) <<< DCP_IFRAC)) / 1000000;
    endfunction

    localparam fx_t DCP_TO_XYZ [9] = '{
        fx_t'(cfx(430574)), fx_t'(cfx(341550)), fx_t'(cfx(178325)),
        fx_t'(cfx(222015)), fx_t'(cfx(706655)), fx_t'(cfx(71330)),
        fx_t'(cfx(20183)), fx_t'(cfx(129553)), fx_t'(cfx(939180))
    };
    localparam fx_t DCP_TO_RGB [9] = '{
        fx_t'(cfx(3063218)), fx_t'(cfx(-1393325)), fx_t'(cfx(-475802)),
        fx_t'(cfx(-969243)), fx_t'(cfx(1875966)), fx_t'(cfx(41555)),
        fx_t'(cfx(67871)), fx_t'(cfx(-228834)), fx_t'(cfx(1069251))
    };

    localparam longint DCP_WHITE_X = cfx(312713);
    localparam longint DCP_WHITE_Y = cfx(329016);
    localparam longint DCP_WHITE_Z = cfx(358271);
    localparam fx_t DCP_RATIO_X = fx_t'((DCP_WHITE_X <<< DCP_IFRAC) / DCP_WHITE_Y);
    localparam fx_t DCP_RATIO_Z = fx_t'((DCP_WHITE_Z <<< DCP_IFRAC) / DCP_WHITE_Y);

    function automatic fx_t sat32(input logic signed [63:0] x);
        fx_t r;
        if (x > 64'sd2147483647) begin
            r = DCP_SAT_HI;
        end else if (x < -64'sd2147483648) begin
            r = DCP_SAT_LO;
        end else begin
            r = x[DCP_W-1:0];
        end
        return r;
    endfunction

    function automatic fx_t add_sat(input fx_t a, input fx_t b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        wa = a;
        wb = b;
        return sat32(wa + wb);
    endfunction

    function automatic fx_t sub_sat(input fx_t a, input fx_t b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        wa = a;
        wb = b;
        return sat32(wa - wb);
    endfunction

    function automatic logic signed [63:0] mul_fx(input fx_t a, input fx_t b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic fx_t rnd_sat(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + (64'sd1 <<< (DCP_IFRAC - 1))) >>> DCP_IFRAC;
        return sat32(t);
    endfunction

    function automatic fx_t cfg_fx(input logic signed [DCP_CFG_W-1:0] r);
        return {{(DCP_W - DCP_CFG_W - DCP_CFG_SHIFT){r[DCP_CFG_W-1]}}, r,
                {DCP_CFG_SHIFT{1'b0}}};
    endfunction

endpackage

### hdl/dcp_ifs.sv
// ----------------------------------------------------------------------------
// Dichromat color projection channels
// Valid/ready channels for the input pixel and the simulated result.
// ----------------------------------------------------------------------------
interface dcp_pix_in_if;
    logic valid;
    logic ready;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface dcp_pix_out_if;
    logic valid;
    logic ready;
    logic signed [16:0] red_out;
    logic signed [16:0] green_out;
    logic signed [16:0] blue_out;
    logic degenerate;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output degenerate, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input degenerate, output ready);
endinterface

### hdl/dcp_div.sv
// ----------------------------------------------------------------------------
// Dichromat color projection divider
// Pipelined signed fixed-point divider, one quotient bit per stage, with
// saturation, zero-divisor flag and a sideband that travels with each item.
// ----------------------------------------------------------------------------
module dcp_div #(
    parameter int LANES = 1,
    parameter int TAG_W = 1
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  dcp_pkg::fx_t num [LANES],
    input  dcp_pkg::fx_t den [LANES],
    input  logic [TAG_W-1:0] in_tag,
    output logic out_valid,
    output dcp_pkg::fx_t quo [LANES],
    output logic [LANES-1:0] zero,
    output logic [TAG_W-1:0] out_tag
);
    import dcp_pkg::*;

    localparam int STEPS = DCP_DIV_STEPS;
    localparam int LEAD = DCP_DIV_LEAD;

    logic [STEPS+1:0] vld_reg;
    logic [TAG_W-1:0] tag_reg [STEPS+1];
    logic [DCP_W:0] rem_reg [STEPS+1][LANES];
    logic [DCP_W:0] dvs_reg [STEPS+1][LANES];
    logic [STEPS-1:0] low_reg [STEPS+1][LANES];
    logic [STEPS-1:0] quo_reg [STEPS+1][LANES];
    logic neg_reg [STEPS+1][LANES];
    logic zero_reg [STEPS+1][LANES];
    logic ovf_reg [STEPS+1][LANES];
    fx_t quo_out_reg [LANES];
    logic [LANES-1:0] zero_out_reg;
    logic [TAG_W-1:0] tag_out_reg;

    logic [DCP_W:0] ma [LANES];
    logic [DCP_W:0] mb [LANES];
    logic [DCP_W:0] trial [STEPS][LANES];
    logic fits [STEPS][LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ma[l] = num[l][DCP_W-1] ? (33'd0 - {num[l][DCP_W-1], num[l]}) : {1'b0, num[l]};
            mb[l] = den[l][DCP_W-1] ? (33'd0 - {den[l][DCP_W-1], den[l]}) : {1'b0, den[l]};
        end
        for (int s = 0; s < STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[s][l] = {rem_reg[s][l][DCP_W-1:0], low_reg[s][l][STEPS-1]};
                fits[s][l] = trial[s][l] >= dvs_reg[s][l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= 33'(ma[l] >> LEAD);
                dvs_reg[0][l] <= mb[l];
                low_reg[0][l] <= {ma[l][LEAD-1:0], {(STEPS - LEAD){1'b0}}};
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= num[l][DCP_W-1] ^ den[l][DCP_W-1];
                zero_reg[0][l] <= (den[l] == '0);
                ovf_reg[0][l] <= {{LEAD{1'b0}}, ma[l]} >= {mb[l], {LEAD{1'b0}}};
            end
            for (int s = 1; s <= STEPS; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= fits[s-1][l] ? (trial[s-1][l] - dvs_reg[s-1][l])
                                                  : trial[s-1][l];
                    dvs_reg[s][l] <= dvs_reg[s-1][l];
                    low_reg[s][l] <= {low_reg[s-1][l][STEPS-2:0], 1'b0};
                    quo_reg[s][l] <= {quo_reg[s-1][l][STEPS-2:0], fits[s-1][l]};
                    neg_reg[s][l] <= neg_reg[s-1][l];
                    zero_reg[s][l] <= zero_reg[s-1][l];
                    ovf_reg[s][l] <= ovf_reg[s-1][l];
                end
            end
            tag_out_reg <= tag_reg[STEPS];
            for (int l = 0; l < LANES; l++)
            begin
                zero_out_reg[l] <= zero_reg[STEPS][l];
                if (zero_reg[STEPS][l])
                begin
                    quo_out_reg[l] <= '0;
                end
                else if (ovf_reg[STEPS][l])
                begin
                    quo_out_reg[l] <= neg_reg[STEPS][l] ? DCP_SAT_LO : DCP_SAT_HI;
                end
                else if (neg_reg[STEPS][l])
                begin
                    quo_out_reg[l] <= 32'd0 - {1'b0, quo_reg[STEPS][l]};
                end
                else
                begin
                    quo_out_reg[l] <= {1'b0, quo_reg[STEPS][l]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS:0], in_valid};
        end
    end

    assign out_valid = vld_reg[STEPS+1];
    assign quo = quo_out_reg;
    assign zero = zero_out_reg;
    assign out_tag = tag_out_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STEPS] && !zero_reg[STEPS][0] && !ovf_reg[STEPS][0]
        |-> rem_reg[STEPS][0] < dvs_reg[STEPS][0])
        else $error("divider remainder not below divisor");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("divider valid chain moved while stalled");
`endif

endmodule

### hdl/dichromat_color_projection_unit.sv
// ----------------------------------------------------------------------------
// Dichromat color projection unit
// Projects linear RGB pixels onto a dichromat color axis and pulls the
// result back into gamut toward neutral gray.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the pixel channel (valid/ready, Q1.15 unsigned components)
// and results leave on the result channel (signed Q2.15, saturated, with a
// degenerate flag set when divider two, three or four met a zero divisor).
// A fully pipelined datapath takes one item per clock while no stall holds
// it. Each item passes through five chained pipelined dividers of 33 stages
// each plus 19 arithmetic stages.
// Items leave in order, one per cycle while the receiver is ready.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and pixel.ready falls; nothing is lost or repeated.
// The four axis and confusion-point registers (APB byte addresses 0, 4, 8
// and 12) must be written while no items are in flight; the block does not
// enforce this. Reset empties the pipeline and loads the protanope defaults.
// ----------------------------------------------------------------------------
module dichromat_color_projection_unit #(
    parameter int FRACTION_BITS = dcp_pkg::DCP_FRACTION_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [dcp_pkg::DCP_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    dcp_pix_in_if.sink pixel,
    dcp_pix_out_if.source result
);
    import dcp_pkg::*;

    localparam int IN_SH = DCP_IFRAC - FRACTION_BITS;
    localparam int OUT_SH = DCP_IFRAC - FRACTION_BITS;
    localparam logic signed [63:0] OUT_RND = (64'sd1 <<< OUT_SH) >>> 1;

    typedef struct packed {
        fx_t y;
        fx_t nx;
        fx_t nz;
    } d1_tag_t;

    typedef struct packed {
        fx_t ux;
        fx_t uy;
        fx_t y;
        fx_t nx;
        fx_t nz;
    } d2_tag_t;

    typedef struct packed {
        fx_t clm;
        fx_t clyi;
        fx_t y;
        fx_t nx;
        fx_t nz;
        logic bad;
    } d3_tag_t;

    typedef struct packed {
        fx_t y;
        fx_t nx;
        fx_t nz;
        logic bad;
    } d4_tag_t;

    typedef struct packed {
        fx_t [2:0] s;
        fx_t [2:0] d;
        logic bad;
    } d5_tag_t;

    // Configuration registers.
    logic signed [DCP_CFG_W-1:0] cu_reg, cv_reg, slope_reg, icpt_reg;
    logic [1:0] cfg_idx;
    logic [DCP_CFG_W-1:0] rd_sel;

    assign cfg_idx = paddr[DCP_ADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cu_reg <= DCP_CU_RESET;
            cv_reg <= DCP_CV_RESET;
            slope_reg <= DCP_SLOPE_RESET;
            icpt_reg <= DCP_ICPT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                DCP_REG_CU: cu_reg <= pwdata[DCP_CFG_W-1:0];
                DCP_REG_CV: cv_reg <= pwdata[DCP_CFG_W-1:0];
                DCP_REG_SLOPE: slope_reg <= pwdata[DCP_CFG_W-1:0];
                DCP_REG_ICPT: icpt_reg <= pwdata[DCP_CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            DCP_REG_CU: rd_sel = cu_reg;
            DCP_REG_CV: rd_sel = cv_reg;
            DCP_REG_SLOPE: rd_sel = slope_reg;
            DCP_REG_ICPT: rd_sel = icpt_reg;
        endcase
        prdata = {{(32 - DCP_CFG_W){rd_sel[DCP_CFG_W-1]}}, rd_sel};
    end

    fx_t cu_fx, cv_fx, slope_fx, icpt_fx;
    assign cu_fx = cfg_fx(cu_reg);
    assign cv_fx = cfg_fx(cv_reg);
    assign slope_fx = cfg_fx(slope_reg);
    assign icpt_fx = cfg_fx(icpt_reg);

    // Global pipeline advance.
    logic en;
    logic out_vld_reg;
    assign en = !out_vld_reg || result.ready;
    assign pixel.ready = en;

    logic a_vld_reg, b_vld_reg, c_vld_reg, e_vld_reg, f_vld_reg, g_vld_reg, h_vld_reg;
    logic i_vld_reg, j_vld_reg, k_vld_reg, l_vld_reg, m_vld_reg, n_vld_reg, o_vld_reg;
    logic p_vld_reg, q_vld_reg, r_vld_reg, s_vld_reg;
    logic d1_vld, d2_vld, d3_vld, d4_vld, d5_vld;

    fx_t rgb_in [3];
    assign rgb_in[0] = fx_t'({16'd0, pixel.red_in} << IN_SH);
    assign rgb_in[1] = fx_t'({16'd0, pixel.green_in} << IN_SH);
    assign rgb_in[2] = fx_t'({16'd0, pixel.blue_in} << IN_SH);

    // Stages A to C: RGB to XYZ, chromaticity divisor, white reference.
    logic signed [63:0] a_p_reg [3][3];
    fx_t b_xyz_reg [3];
    fx_t c_sum_reg, c_x_reg, c_y_reg, c_nx_reg, c_nz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    a_p_reg[i][j] <= mul_fx(DCP_TO_XYZ[3*i+j], rgb_in[j]);
                end
                b_xyz_reg[i] <= rnd_sat(a_p_reg[i][0] + a_p_reg[i][1] + a_p_reg[i][2]);
            end
            c_sum_reg <= sat32(64'(b_xyz_reg[0]) + 64'(b_xyz_reg[1]) + 64'(b_xyz_reg[2]));
            c_x_reg <= b_xyz_reg[0];
            c_y_reg <= b_xyz_reg[1];
            c_nx_reg <= rnd_sat(mul_fx(DCP_RATIO_X, b_xyz_reg[1]));
            c_nz_reg <= rnd_sat(mul_fx(DCP_RATIO_Z, b_xyz_reg[1]));
        end
    end

    fx_t d1_num [2], d1_den [2], d1_quo [2];
    d1_tag_t d1_tin, d1_tout;
    assign d1_num[0] = c_x_reg;
    assign d1_num[1] = c_y_reg;
    assign d1_den[0] = c_sum_reg;
    assign d1_den[1] = c_sum_reg;
    assign d1_tin = '{y: c_y_reg, nx: c_nx_reg, nz: c_nz_reg};

    dcp_div #(.LANES(2), .TAG_W($bits(d1_tag_t))) u_div_uv (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c_vld_reg),
        .num(d1_num), .den(d1_den), .in_tag(d1_tin),
        .out_valid(d1_vld), .quo(d1_quo), .zero(), .out_tag(d1_tout)
    );

    // Stage E: confusion line slope operands.
    fx_t e_num_reg, e_den_reg;
    d2_tag_t e_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d1_quo[0] < cu_fx)
            begin
                e_num_reg <= sub_sat(cv_fx, d1_quo[1]);
                e_den_reg <= sub_sat(cu_fx, d1_quo[0]);
            end
            else
            begin
                e_num_reg <= sub_sat(d1_quo[1], cv_fx);
                e_den_reg <= sub_sat(d1_quo[0], cu_fx);
            end
            e_tag_reg <= '{ux: d1_quo[0], uy: d1_quo[1], y: d1_tout.y,
                           nx: d1_tout.nx, nz: d1_tout.nz};
        end
    end

    fx_t d2_num [1], d2_den [1], d2_quo [1];
    logic [0:0] d2_zero;
    d2_tag_t d2_tout;
    assign d2_num[0] = e_num_reg;
    assign d2_den[0] = e_den_reg;

    dcp_div #(.LANES(1), .TAG_W($bits(d2_tag_t))) u_div_clm (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(e_vld_reg),
        .num(d2_num), .den(d2_den), .in_tag(e_tag_reg),
        .out_valid(d2_vld), .quo(d2_quo), .zero(d2_zero), .out_tag(d2_tout)
    );

    // Stages F to H: confusion line intercept and axis intersection operands.
    logic signed [63:0] f_p_reg;
    fx_t f_clm_reg, f_uy_reg, f_y_reg, f_nx_reg, f_nz_reg;
    logic f_bad_reg;
    fx_t g_clyi_reg, g_den_reg, g_clm_reg, g_y_reg, g_nx_reg, g_nz_reg;
    logic g_bad_reg;
    fx_t h_num_reg, h_den_reg;
    d3_tag_t h_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_p_reg <= mul_fx(d2_tout.ux, d2_quo[0]);
            f_clm_reg <= d2_quo[0];
            f_uy_reg <= d2_tout.uy;
            f_y_reg <= d2_tout.y;
            f_nx_reg <= d2_tout.nx;
            f_nz_reg <= d2_tout.nz;
            f_bad_reg <= d2_zero[0];

            g_clyi_reg <= sub_sat(f_uy_reg, rnd_sat(f_p_reg));
            g_den_reg <= sub_sat(f_clm_reg, slope_fx);
            g_clm_reg <= f_clm_reg;
            g_y_reg <= f_y_reg;
            g_nx_reg <= f_nx_reg;
            g_nz_reg <= f_nz_reg;
            g_bad_reg <= f_bad_reg;

            h_num_reg <= sub_sat(icpt_fx, g_clyi_reg);
            h_den_reg <= g_den_reg;
            h_tag_reg <= '{clm: g_clm_reg, clyi: g_clyi_reg, y: g_y_reg,
                           nx: g_nx_reg, nz: g_nz_reg, bad: g_bad_reg};
        end
    end

    fx_t d3_num [1], d3_den [1], d3_quo [1];
    logic [0:0] d3_zero;
    d3_tag_t d3_tout;
    assign d3_num[0] = h_num_reg;
    assign d3_den[0] = h_den_reg;

    dcp_div #(.LANES(1), .TAG_W($bits(d3_tag_t))) u_div_dx (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(h_vld_reg),
        .num(d3_num), .den(d3_den), .in_tag(h_tag_reg),
        .out_valid(d3_vld), .quo(d3_quo), .zero(d3_zero), .out_tag(d3_tout)
    );

    // Stages I to L: intersection point and rebuilt X and Z numerators.
    logic signed [63:0] i_p2_reg, i_q1_reg;
    fx_t i_dx_reg, i_clyi_reg, i_y_reg, i_nx_reg, i_nz_reg;
    logic i_bad_reg;
    fx_t j_dy_reg, j_m1_reg, j_dx_reg, j_y_reg, j_nx_reg, j_nz_reg;
    logic j_bad_reg;
    fx_t k_t_reg, k_m1_reg, k_dy_reg, k_y_reg, k_nx_reg, k_nz_reg;
    logic k_bad_reg;
    fx_t l_m1_reg, l_m2_reg, l_dy_reg;
    d4_tag_t l_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_p2_reg <= mul_fx(d3_tout.clm, d3_quo[0]);
            i_q1_reg <= mul_fx(d3_quo[0], d3_tout.y);
            i_dx_reg <= d3_quo[0];
            i_clyi_reg <= d3_tout.clyi;
            i_y_reg <= d3_tout.y;
            i_nx_reg <= d3_tout.nx;
            i_nz_reg <= d3_tout.nz;
            i_bad_reg <= d3_tout.bad | d3_zero[0];

            j_dy_reg <= add_sat(rnd_sat(i_p2_reg), i_clyi_reg);
            j_m1_reg <= rnd_sat(i_q1_reg);
            j_dx_reg <= i_dx_reg;
            j_y_reg <= i_y_reg;
            j_nx_reg <= i_nx_reg;
            j_nz_reg <= i_nz_reg;
            j_bad_reg <= i_bad_reg;

            k_t_reg <= sub_sat(DCP_ONE, add_sat(j_dx_reg, j_dy_reg));
            k_m1_reg <= j_m1_reg;
            k_dy_reg <= j_dy_reg;
            k_y_reg <= j_y_reg;
            k_nx_reg <= j_nx_reg;
            k_nz_reg <= j_nz_reg;
            k_bad_reg <= j_bad_reg;

            l_m1_reg <= k_m1_reg;
            l_m2_reg <= rnd_sat(mul_fx(k_t_reg, k_y_reg));
            l_dy_reg <= k_dy_reg;
            l_tag_reg <= '{y: k_y_reg, nx: k_nx_reg, nz: k_nz_reg, bad: k_bad_reg};
        end
    end

    fx_t d4_num [2], d4_den [2], d4_quo [2];
    logic [1:0] d4_zero;
    d4_tag_t d4_tout;
    assign d4_num[0] = l_m1_reg;
    assign d4_num[1] = l_m2_reg;
    assign d4_den[0] = l_dy_reg;
    assign d4_den[1] = l_dy_reg;

    dcp_div #(.LANES(2), .TAG_W($bits(d4_tag_t))) u_div_xz (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(l_vld_reg),
        .num(d4_num), .den(d4_den), .in_tag(l_tag_reg),
        .out_valid(d4_vld), .quo(d4_quo), .zero(d4_zero), .out_tag(d4_tout)
    );

    // Stages M to O: back to RGB for the projected color and the gray offset.
    fx_t m_s_reg [3];
    fx_t m_d_reg [2];
    logic m_bad_reg;
    logic signed [63:0] n_sp_reg [3][3];
    logic signed [63:0] n_dp_reg [3][2];
    logic n_bad_reg;
    fx_t o_s_reg [3];
    fx_t o_d_reg [3];
    logic o_bad_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_s_reg[0] <= d4_quo[0];
            m_s_reg[1] <= d4_tout.y;
            m_s_reg[2] <= d4_quo[1];
            m_d_reg[0] <= sub_sat(d4_tout.nx, d4_quo[0]);
            m_d_reg[1] <= sub_sat(d4_tout.nz, d4_quo[1]);
            m_bad_reg <= d4_tout.bad | (|d4_zero);

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    n_sp_reg[i][j] <= mul_fx(DCP_TO_RGB[3*i+j], m_s_reg[j]);
                end
                n_dp_reg[i][0] <= mul_fx(DCP_TO_RGB[3*i], m_d_reg[0]);
                n_dp_reg[i][1] <= mul_fx(DCP_TO_RGB[3*i+2], m_d_reg[1]);
                o_s_reg[i] <= rnd_sat(n_sp_reg[i][0] + n_sp_reg[i][1] + n_sp_reg[i][2]);
                o_d_reg[i] <= rnd_sat(n_dp_reg[i][0] + n_dp_reg[i][1]);
            end
            n_bad_reg <= m_bad_reg;
            o_bad_reg <= n_bad_reg;
        end
    end

    fx_t d5_quo [3];
    d5_tag_t d5_tin, d5_tout;
    assign d5_tin = '{s: {o_s_reg[2], o_s_reg[1], o_s_reg[0]},
                      d: {o_d_reg[2], o_d_reg[1], o_d_reg[0]}, bad: o_bad_reg};

    dcp_div #(.LANES(3), .TAG_W($bits(d5_tag_t))) u_div_adj (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(o_vld_reg),
        .num(o_s_reg), .den(o_d_reg), .in_tag(d5_tin),
        .out_valid(d5_vld), .quo(d5_quo), .zero(), .out_tag(d5_tout)
    );

    // Stages P to S: gamut adjustment and blend toward gray.
    fx_t p_adj_reg [3];
    fx_t p_s_reg [3];
    fx_t p_d_reg [3];
    logic p_bad_reg;
    fx_t q_adjust_reg;
    fx_t q_s_reg [3];
    fx_t q_d_reg [3];
    logic q_bad_reg;
    logic signed [63:0] r_p_reg [3];
    fx_t r_s_reg [3];
    logic r_bad_reg;
    fx_t s_v_reg [3];
    logic s_bad_reg;
    fx_t adjust_next;

    always_comb
    begin
        adjust_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (p_adj_reg[i] >= 0 && p_adj_reg[i] <= DCP_ONE && p_adj_reg[i] > adjust_next)
            begin
                adjust_next = p_adj_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (d5_tout.d[i] != '0)
                begin
                    p_adj_reg[i] <= sub_sat(d5_tout.s[i][DCP_W-1] ? fx_t'(0) : DCP_ONE,
                                            d5_quo[i]);
                end
                else
                begin
                    p_adj_reg[i] <= '0;
                end
                p_s_reg[i] <= d5_tout.s[i];
                p_d_reg[i] <= d5_tout.d[i];
                q_s_reg[i] <= p_s_reg[i];
                q_d_reg[i] <= p_d_reg[i];
                r_p_reg[i] <= mul_fx(q_adjust_reg, q_d_reg[i]);
                r_s_reg[i] <= q_s_reg[i];
                s_v_reg[i] <= add_sat(r_s_reg[i], rnd_sat(r_p_reg[i]));
            end
            p_bad_reg <= d5_tout.bad;
            q_adjust_reg <= adjust_next;
            q_bad_reg <= p_bad_reg;
            r_bad_reg <= q_bad_reg;
            s_bad_reg <= r_bad_reg;
        end
    end

    // Output register: rounding to the output format and clamping.
    logic signed [DCP_OUT_W-1:0] out_ch_reg [3];
    logic out_bad_reg;
    logic signed [63:0] vr [3];
    logic signed [DCP_OUT_W-1:0] out_ch_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vr[i] = (64'(s_v_reg[i]) + OUT_RND) >>> OUT_SH;
            if (vr[i] > 64'sd65535)
            begin
                out_ch_next[i] = 17'sd65535;
            end
            else if (vr[i] < -64'sd65536)
            begin
                out_ch_next[i] = -17'sd65536;
            end
            else
            begin
                out_ch_next[i] = vr[i][DCP_OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ch_reg <= out_ch_next;
            out_bad_reg <= s_bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
            l_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= pixel.valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            e_vld_reg <= d1_vld;
            f_vld_reg <= d2_vld;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= d3_vld;
            j_vld_reg <= i_vld_reg;
            k_vld_reg <= j_vld_reg;
            l_vld_reg <= k_vld_reg;
            m_vld_reg <= d4_vld;
            n_vld_reg <= m_vld_reg;
            o_vld_reg <= n_vld_reg;
            p_vld_reg <= d5_vld;
            q_vld_reg <= p_vld_reg;
            r_vld_reg <= q_vld_reg;
            s_vld_reg <= r_vld_reg;
            out_vld_reg <= s_vld_reg;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.red_out = out_ch_reg[0];
    assign result.green_out = out_ch_reg[1];
    assign result.blue_out = out_ch_reg[2];
    assign result.degenerate = out_bad_reg;

    logic [17:0] stage_vld;
    assign stage_vld = {a_vld_reg, b_vld_reg, c_vld_reg, e_vld_reg, f_vld_reg, g_vld_reg,
                        h_vld_reg, i_vld_reg, j_vld_reg, k_vld_reg, l_vld_reg, m_vld_reg,
                        n_vld_reg, o_vld_reg, p_vld_reg, q_vld_reg, r_vld_reg, s_vld_reg};

`ifndef SYNTHESIS
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stage_vld))
        else $error("pipeline valid bits moved during a stall");
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> a_vld_reg)
        else $error("accepted item did not enter the first stage");
    a_bubble_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !s_vld_reg) |=> !result.valid)
        else $error("result shown without an item behind it");
`endif

endmodule

### sim/tb_dichromat_color_projection_unit.sv
// ----------------------------------------------------------------------------
// Dichromat color projection unit testbench
// Drives pixels through the valid/ready channels under several idling
// phases and register settings, predicts every result in fixed point and
// compares each received result field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_dichromat_color_projection_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dcp_pkg::*;

    localparam int LATENCY = 184;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [16:0] red;
        logic signed [16:0] green;
        logic signed [16:0] blue;
        logic degenerate;
    } sim_pixel_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [DCP_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    dcp_pix_in_if pixel ();
    dcp_pix_out_if result ();

    dichromat_color_projection_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .pixel(pixel.sink),
        .result(result.source)
    );

    sim_pixel_t expected_pixels[$];
    int failures = 0;
    longint cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    longint cu_reg;
    longint cv_reg;
    longint slope_reg;
    longint icpt_reg;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint sat_wide(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return sat_wide((a * b + (64'sd1 <<< 23)) >>> 24);
    endfunction

    function automatic longint fx_div(input longint a, input longint b, inout bit zero);
        if (b == 0)
        begin
            zero = 1'b1;
            return 0;
        end
        return sat_wide((a * (64'sd1 <<< 24)) / b);
    endfunction

    function automatic longint const_fx(input longint n);
        return (n * (64'sd1 <<< 24)) / 1000000;
    endfunction

    function automatic longint cfg_value(input logic [19:0] r);
        return longint'(signed'(r)) * 256;
    endfunction

    function automatic void apply_matrix(input bit to_display, input longint v[3],
                                         output longint r[3]);
        longint m[9];
        longint acc;
        if (to_display)
            m = '{const_fx(3063218), const_fx(-1393325), const_fx(-475802),
                  const_fx(-969243), const_fx(1875966), const_fx(41555),
                  const_fx(67871), const_fx(-228834), const_fx(1069251)};
        else
            m = '{const_fx(430574), const_fx(341550), const_fx(178325),
                  const_fx(222015), const_fx(706655), const_fx(71330),
                  const_fx(20183), const_fx(129553), const_fx(939180)};
        for (int i = 0; i < 3; i++)
        begin
            acc = m[3*i] * v[0] + m[3*i+1] * v[1] + m[3*i+2] * v[2];
            r[i] = sat_wide((acc + (64'sd1 <<< 23)) >>> 24);
        end
    endfunction

    function automatic sim_pixel_t project_pixel(input logic [15:0] r, input logic [15:0] g,
                                                 input logic [15:0] b);
        longint rgb[3], xyz[3], s_xyz[3], d_xyz[3], s_rgb[3], d_rgb[3];
        longint total, ux, uy, nx, nz, clm, clyi, dx, dy, adjust, adj, v;
        bit bad;
        bit ignore;
        longint chan[3];
        sim_pixel_t p;
        bad = 1'b0;
        ignore = 1'b0;
        ux = 0;
        uy = 0;
        rgb[0] = longint'(r) <<< 9;
        rgb[1] = longint'(g) <<< 9;
        rgb[2] = longint'(b) <<< 9;
        apply_matrix(1'b0, rgb, xyz);
        total = sat_wide(xyz[0] + xyz[1] + xyz[2]);
        if (total != 0)
        begin
            ux = fx_div(xyz[0], total, ignore);
            uy = fx_div(xyz[1], total, ignore);
        end
        nx = fx_mul(fx_div(const_fx(312713), const_fx(329016), ignore), xyz[1]);
        nz = fx_mul(fx_div(const_fx(358271), const_fx(329016), ignore), xyz[1]);
        if (ux < cu_reg)
            clm = fx_div(sat_wide(cv_reg - uy), sat_wide(cu_reg - ux), bad);
        else
            clm = fx_div(sat_wide(uy - cv_reg), sat_wide(ux - cu_reg), bad);
        clyi = sat_wide(uy - fx_mul(ux, clm));
        dx = fx_div(sat_wide(icpt_reg - clyi), sat_wide(clm - slope_reg), bad);
        dy = sat_wide(fx_mul(clm, dx) + clyi);
        s_xyz[0] = fx_div(fx_mul(dx, xyz[1]), dy, bad);
        s_xyz[1] = xyz[1];
        s_xyz[2] = fx_div(fx_mul(sat_wide((64'sd1 <<< 24) - sat_wide(dx + dy)), xyz[1]),
                          dy, bad);
        apply_matrix(1'b1, s_xyz, s_rgb);
        d_xyz[0] = sat_wide(nx - s_xyz[0]);
        d_xyz[1] = 0;
        d_xyz[2] = sat_wide(nz - s_xyz[2]);
        apply_matrix(1'b1, d_xyz, d_rgb);
        adjust = 0;
        for (int i = 0; i < 3; i++)
        begin
            adj = 0;
            if (d_rgb[i] != 0)
                adj = sat_wide((s_rgb[i] < 0 ? 0 : (64'sd1 <<< 24))
                               - fx_div(s_rgb[i], d_rgb[i], ignore));
            if (adj >= 0 && adj <= (64'sd1 <<< 24) && adj > adjust)
                adjust = adj;
        end
        for (int i = 0; i < 3; i++)
        begin
            v = sat_wide(s_rgb[i] + fx_mul(adjust, d_rgb[i]));
            v = (v + 256) >>> 9;
            if (v > 65535)
                v = 65535;
            if (v < -65536)
                v = -65536;
            chan[i] = v;
        end
        p.red = chan[0][16:0];
        p.green = chan[1][16:0];
        p.blue = chan[2][16:0];
        p.degenerate = bad;
        return p;
    endfunction

    task automatic write_register(input logic [1:0] index, input logic [19:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DCP_ADDR_W'(index) << 2;
        pwdata <= {{12{value[19]}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            DCP_REG_CU: cu_reg = cfg_value(value);
            DCP_REG_CV: cv_reg = cfg_value(value);
            DCP_REG_SLOPE: slope_reg = cfg_value(value);
            default: icpt_reg = cfg_value(value);
        endcase
    endtask

    // The item stays offered after acceptance so that the next one can follow
    // in the very next cycle; stop_sending withdraws it.
    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            pixel.valid <= 1'b0;
        end
        @(negedge clk);
        pixel.valid <= 1'b1;
        pixel.red_in <= r;
        pixel.green_in <= g;
        pixel.blue_in <= b;
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
        expected_pixels.push_back(project_pixel(r, g, b));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        pixel.valid <= 1'b0;
    endtask

    task automatic drain_results();
        stop_sending();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20)
            @(posedge clk);
    endtask

    function automatic logic [15:0] random_channel();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 16'd0;
        if (pick == 1)
            return 16'd32768;
        if (pick == 2)
            return 16'($urandom_range(65535));
        return 16'($urandom_range(32768));
    endfunction

    always @(negedge clk)
    begin
        result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        sim_pixel_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result item");
                failures++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (result.red_out !== want.red)
                begin
                    $error("red_out expected %0d actual %0d", want.red, result.red_out);
                    failures++;
                end
                if (result.green_out !== want.green)
                begin
                    $error("green_out expected %0d actual %0d", want.green, result.green_out);
                    failures++;
                end
                if (result.blue_out !== want.blue)
                begin
                    $error("blue_out expected %0d actual %0d", want.blue, result.blue_out);
                    failures++;
                end
                if (result.degenerate !== want.degenerate)
                begin
                    $error("degenerate expected %0d actual %0d", want.degenerate,
                           result.degenerate);
                    failures++;
                end
            end
        end
    end

    task automatic test_directed();
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'd32768, 16'd32768, 16'd32768);
        send_pixel(16'd32768, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd32768, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd32768);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd1, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd1, 16'd1);
        send_pixel(16'h5555, 16'hAAAA, 16'h7FFF);
        send_pixel(16'd16384, 16'd16384, 16'd16384);
        send_pixel(16'd32768, 16'd32768, 16'd0);
        send_pixel(16'd0, 16'd32768, 16'd32768);
    endtask

    task automatic test_degenerate_settings();
        drain_results();
        // A confusion point at the origin with a zero axis line makes black and
        // gray pixels hit zero divisors along the projection.
        write_register(DCP_REG_CU, 20'd0);
        write_register(DCP_REG_CV, 20'd0);
        write_register(DCP_REG_SLOPE, 20'd0);
        write_register(DCP_REG_ICPT, 20'd0);
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'd1000, 16'd1000, 16'd1000);
        send_pixel(16'd32768, 16'd0, 16'd0);
        // Confusion point at the D65 white chromaticity of gray.
        drain_results();
        write_register(DCP_REG_CU, 20'd20495);
        write_register(DCP_REG_CV, 20'd21563);
        send_pixel(16'd32768, 16'd32768, 16'd32768);
        send_pixel(16'd8192, 16'd8192, 16'd8192);
        drain_results();
        write_register(DCP_REG_CU, 20'h7FFFF);
        write_register(DCP_REG_CV, 20'h80000);
        write_register(DCP_REG_SLOPE, 20'h7FFFF);
        write_register(DCP_REG_ICPT, 20'h80000);
        send_pixel(16'd32768, 16'd12000, 16'd500);
        send_pixel(16'd0, 16'd0, 16'd0);
        drain_results();
        write_register(DCP_REG_CU, 20'h80000);
        write_register(DCP_REG_CV, 20'h7FFFF);
        write_register(DCP_REG_SLOPE, 20'h80000);
        write_register(DCP_REG_ICPT, 20'h7FFFF);
        send_pixel(16'd100, 16'd32768, 16'd20000);
        send_pixel(16'hFFFF, 16'd0, 16'hFFFF);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count,
                                     input bit random_regs);
        drain_results();
        if (random_regs)
        begin
            write_register(DCP_REG_CU, 20'($urandom_range(78000, 0)));
            write_register(DCP_REG_CV, 20'($urandom_range(70000, 0)));
            write_register(DCP_REG_SLOPE, 20'($urandom));
            write_register(DCP_REG_ICPT, 20'($urandom));
        end
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
            send_pixel(random_channel(), random_channel(), random_channel());
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_pause_until_empty();
        send_pixel(16'd12345, 16'd23456, 16'd3456);
        stop_sending();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        send_pixel(16'd30000, 16'd2000, 16'd9000);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pixel.valid = 1'b0;
        pixel.red_in = '0;
        pixel.green_in = '0;
        pixel.blue_in = '0;
        cu_reg = cfg_value(DCP_CU_RESET);
        cv_reg = cfg_value(DCP_CV_RESET);
        slope_reg = cfg_value(DCP_SLOPE_RESET);
        icpt_reg = cfg_value(DCP_ICPT_RESET);
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phase(0, 0, 80, 1'b0);
        test_pause_until_empty();
        test_degenerate_settings();
        test_random_phase(62, 0, 90, 1'b1);
        test_random_phase(0, 62, 90, 1'b1);
        test_random_phase(14, 14, 90, 1'b1);
        drain_results();
        write_register(DCP_REG_CU, DCP_CU_RESET);
        write_register(DCP_REG_CV, DCP_CV_RESET);
        write_register(DCP_REG_SLOPE, DCP_SLOPE_RESET);
        write_register(DCP_REG_ICPT, DCP_ICPT_RESET);
        test_random_phase(0, 0, 80, 1'b0);
        drain_results();

        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### sim.f
hdl/dcp_pkg.sv
hdl/dcp_ifs.sv
hdl/dcp_div.sv
hdl/dichromat_color_projection_unit.sv
sim/tb_dichromat_color_projection_unit.sv
